>>> sv/assert_macros.svh
// Assertion macros shared by the heartbeat registry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define HNR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heartbeat registry check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define HNR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heartbeat registry check failed");

`endif

>>> sv/hnr_pkg.sv
// Types, codes and constants of the heartbeat node registry.
package hnr_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);

	// Input commands.
	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_HMI    = 2'd3;

	// Result event codes.
	localparam logic [2:0] EV_STORED = 3'd0;
	localparam logic [2:0] EV_FULL   = 3'd1;
	localparam logic [2:0] EV_LOOKUP = 3'd2;
	localparam logic [2:0] EV_CHANGE = 3'd3;
	localparam logic [2:0] EV_DONE   = 3'd4;

	// Node status codes.
	localparam logic [1:0] ST_ONLINE  = 2'd0;
	localparam logic [1:0] ST_WARNING = 2'd1;
	localparam logic [1:0] ST_OFFLINE = 2'd2;
	localparam logic [1:0] ST_LOST    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_WARNING = 2'd0;
	localparam logic [1:0] REG_OFFLINE = 2'd1;
	localparam logic [1:0] REG_LOST    = 2'd2;
	localparam logic [1:0] REG_HMI     = 2'd3;

	// Threshold test phases, in the order they are tried.
	localparam logic [1:0] PH_LOST    = 2'd0;
	localparam logic [1:0] PH_OFFLINE = 2'd1;
	localparam logic [1:0] PH_WARNING = 2'd2;

	typedef struct packed {
		logic [31:0] mesh;
		logic [7:0]  logical;
		logic [7:0]  kind;
		logic [31:0] heard;
		logic [1:0]  status;
	} slot_t;

	typedef struct packed {
		logic      en;
		slot_idx_t addr;
		slot_t     data;
	} mem_wr_t;

	typedef struct packed {
		logic [31:0] diff;
		logic        eq;
		logic        gt;
	} alu_res_t;

	typedef struct packed {
		logic [2:0]  ev_kind;
		logic        found;
		logic [3:0]  slot;
		logic [31:0] mesh;
		logic [7:0]  logical;
		logic [7:0]  kind;
		logic [1:0]  new_st;
		logic [1:0]  old_st;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_CLASS,
		S_TWR,
		S_TDONE,
		S_STORE,
		S_FULL,
		S_MISS
	} state_t;

	// Low four bits of a slot index, zero-extended when the index is narrower.
	function automatic logic [3:0] to_slot4(slot_idx_t i);
		logic [SLOT_W+3:0] w;
		w = {4'b0, i};
		return w[3:0];
	endfunction

endpackage

>>> sv/hnr_alu.sv
// Shared 32-bit subtract and compare unit used by every scan step.
module hnr_alu import hnr_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output alu_res_t    res
);

	always_comb begin
		res.diff = a - b;
		res.eq   = (a == b);
		res.gt   = (a > b);
	end

endmodule

>>> sv/hnr_slot_mem.sv
// Slot table storage: one write port, one registered read port.
module hnr_slot_mem import hnr_pkg::*; (
	input  logic      clk,
	input  mem_wr_t   wr,
	input  slot_idx_t raddr,
	output slot_t     rdata
);

	slot_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/heartbeat_node_registry_unit.sv
// Top level of the heartbeat node registry: sequencer, config and result register.
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_stall   cmd, mesh_id, node_lid, node_kind, now_ms
//  rsp       out        rsp_valid / rsp_stall   event_kind .. last (one or more per request)
//  cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every scan step reads one slot: a read state, then an evaluate state.
// Tick: the evaluate of an active slot does the subtract; then one to three
// threshold compares and a write back follow.
// The single slot memory port and the one shared compare unit serialise these steps.
// Reset clears the active marks at once; no clearing pass. A stalled result
// holds the sequencer before it loads the next result.
module heartbeat_node_registry_unit import hnr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] mesh_id,
	input  logic [7:0]  node_lid,
	input  logic [7:0]  node_kind,
	input  logic [31:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  event_kind,
	output logic        found,
	output logic [3:0]  slot_index,
	output logic [31:0] out_mesh_id,
	output logic [7:0]  out_logical_id,
	output logic [7:0]  out_node_kind,
	output logic [1:0]  new_status,
	output logic [1:0]  old_status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

	state_t      state_q, state_d;
	logic [SLOTS-1:0] active_q, active_d;
	logic        rsp_valid_q;
	rsp_t        rsp_q, rsp_d;
	logic        out_load;
	logic        out_free;

	logic [31:0] warn_q, off_q, lost_q;
	logic [7:0]  hmi_q;

	logic [1:0]  cmd_q;
	logic [31:0] mesh_q, now_q;
	logic [7:0]  lid_q, kind_q;
	logic        req_take;

	slot_idx_t   idx_q, idx_d;
	slot_idx_t   sel_q, sel_d;
	slot_idx_t   free_q, free_d;
	logic        free_found_q, free_found_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic [1:0]  phase_q, phase_d;
	logic [1:0]  newst_q, newst_d;

	logic [31:0] alu_a, alu_b;
	alu_res_t    alu_res;
	mem_wr_t     mem_wr;
	slot_t       rdata;
	logic        act;
	logic        at_end;
	logic        chg;

	hnr_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	hnr_slot_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign act       = active_q[idx_q];
	assign at_end    = (idx_q == LAST_SLOT);
	assign chg       = (newst_q != rdata.status);

	// Operand selection for the shared unit.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_EVAL: begin
				case (cmd_q)
					CMD_UPDATE: begin
						alu_a = {24'b0, rdata.logical};
						alu_b = {24'b0, lid_q};
					end
					CMD_TICK: begin
						alu_a = now_q;
						alu_b = rdata.heard;
					end
					CMD_LOOKUP: begin
						alu_a = rdata.mesh;
						alu_b = mesh_q;
					end
					default: begin
						alu_a = {24'b0, rdata.logical};
						alu_b = {24'b0, hmi_q};
					end
				endcase
			end
			S_CLASS: begin
				alu_a = elapsed_q;
				case (phase_q)
					PH_LOST:    alu_b = lost_q;
					PH_OFFLINE: alu_b = off_q;
					default:    alu_b = warn_q;
				endcase
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	// Sequencer: next state, scan registers, memory write and result load.
	always_comb begin
		state_d      = state_q;
		active_d     = active_q;
		idx_d        = idx_q;
		sel_d        = sel_q;
		free_d       = free_q;
		free_found_d = free_found_q;
		elapsed_d    = elapsed_q;
		phase_d      = phase_q;
		newst_d      = newst_q;
		mem_wr.en    = 1'b0;
		mem_wr.addr  = idx_q;
		mem_wr.data  = rdata;
		out_load     = 1'b0;
		rsp_d        = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					idx_d        = '0;
					free_found_d = 1'b0;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (cmd_q)
					CMD_UPDATE: begin
						if (act && alu_res.eq) begin
							sel_d   = idx_q;
							state_d = S_STORE;
						end else begin
							if (!act && !free_found_q) begin
								free_d       = idx_q;
								free_found_d = 1'b1;
							end
							if (at_end) begin
								if (free_found_q) begin
									sel_d   = free_q;
									state_d = S_STORE;
								end else if (!act) begin
									sel_d   = idx_q;
									state_d = S_STORE;
								end else begin
									state_d = S_FULL;
								end
							end else begin
								idx_d   = slot_idx_t'(idx_q + 1'b1);
								state_d = S_READ;
							end
						end
					end
					CMD_TICK: begin
						if (act) begin
							elapsed_d = alu_res.diff;
							phase_d   = PH_LOST;
							state_d   = S_CLASS;
						end else if (at_end) begin
							state_d = S_TDONE;
						end else begin
							idx_d   = slot_idx_t'(idx_q + 1'b1);
							state_d = S_READ;
						end
					end
					default: begin
						if (act && alu_res.eq) begin
							// Hit: the read data stays put until the result is taken.
							if (out_free) begin
								out_load      = 1'b1;
								rsp_d.ev_kind = EV_LOOKUP;
								rsp_d.found   = 1'b1;
								rsp_d.slot    = to_slot4(idx_q);
								rsp_d.mesh    = rdata.mesh;
								rsp_d.logical = rdata.logical;
								rsp_d.kind    = rdata.kind;
								rsp_d.new_st  = rdata.status;
								rsp_d.last    = 1'b1;
								state_d       = S_IDLE;
							end
						end else if (at_end) begin
							state_d = S_MISS;
						end else begin
							idx_d   = slot_idx_t'(idx_q + 1'b1);
							state_d = S_READ;
						end
					end
				endcase
			end
			S_CLASS: begin
				if (alu_res.gt) begin
					case (phase_q)
						PH_LOST:    newst_d = ST_LOST;
						PH_OFFLINE: newst_d = ST_OFFLINE;
						default:    newst_d = ST_WARNING;
					endcase
					state_d = S_TWR;
				end else if (phase_q == PH_WARNING) begin
					newst_d = ST_ONLINE;
					state_d = S_TWR;
				end else begin
					phase_d = phase_q + 2'd1;
				end
			end
			S_TWR: begin
				if (!chg || out_free) begin
					mem_wr.en          = 1'b1;
					mem_wr.data.status = newst_q;
					if (chg) begin
						out_load      = 1'b1;
						rsp_d.ev_kind = EV_CHANGE;
						rsp_d.found   = 1'b1;
						rsp_d.slot    = to_slot4(idx_q);
						rsp_d.mesh    = rdata.mesh;
						rsp_d.logical = rdata.logical;
						rsp_d.kind    = rdata.kind;
						rsp_d.new_st  = newst_q;
						rsp_d.old_st  = rdata.status;
					end
					if (at_end) begin
						state_d = S_TDONE;
					end else begin
						idx_d   = slot_idx_t'(idx_q + 1'b1);
						state_d = S_READ;
					end
				end
			end
			S_TDONE: begin
				if (out_free) begin
					out_load      = 1'b1;
					rsp_d.ev_kind = EV_DONE;
					rsp_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_STORE: begin
				if (out_free) begin
					mem_wr.en     = 1'b1;
					mem_wr.addr   = sel_q;
					mem_wr.data   = '{mesh: mesh_q, logical: lid_q, kind: kind_q,
						heard: now_q, status: ST_ONLINE};
					active_d[sel_q] = 1'b1;
					out_load      = 1'b1;
					rsp_d.ev_kind = EV_STORED;
					rsp_d.found   = 1'b1;
					rsp_d.slot    = to_slot4(sel_q);
					rsp_d.mesh    = mesh_q;
					rsp_d.logical = lid_q;
					rsp_d.kind    = kind_q;
					rsp_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FULL: begin
				if (out_free) begin
					out_load      = 1'b1;
					rsp_d.ev_kind = EV_FULL;
					rsp_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_MISS: begin
				if (out_free) begin
					out_load      = 1'b1;
					rsp_d.ev_kind = EV_LOOKUP;
					rsp_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
			warn_q      <= 32'd3000;
			off_q       <= 32'd10000;
			lost_q      <= 32'd30000;
			hmi_q       <= 8'd1;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WARNING: warn_q <= cfg_data;
					REG_OFFLINE: off_q  <= cfg_data;
					REG_LOST:    lost_q <= cfg_data;
					REG_HMI:     hmi_q  <= cfg_data[7:0];
					default:     ;
				endcase
			end
		end
	end

	// Payload and scan registers; no reset needed.
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q  <= cmd;
			mesh_q <= mesh_id;
			lid_q  <= node_lid;
			kind_q <= node_kind;
			now_q  <= now_ms;
		end
		if (out_load) begin
			rsp_q <= rsp_d;
		end
		idx_q        <= idx_d;
		sel_q        <= sel_d;
		free_q       <= free_d;
		free_found_q <= free_found_d;
		elapsed_q    <= elapsed_d;
		phase_q      <= phase_d;
		newst_q      <= newst_d;
	end

	assign rsp_valid      = rsp_valid_q;
	assign event_kind     = rsp_q.ev_kind;
	assign found          = rsp_q.found;
	assign slot_index     = rsp_q.slot;
	assign out_mesh_id    = rsp_q.mesh;
	assign out_logical_id = rsp_q.logical;
	assign out_node_kind  = rsp_q.kind;
	assign new_status     = rsp_q.new_st;
	assign old_status     = rsp_q.old_st;
	assign last           = rsp_q.last;

	`HNR_ASSERT_IMPL(a_change_differs, rsp_valid_q && rsp_q.ev_kind == EV_CHANGE, rsp_q.new_st != rsp_q.old_st && !rsp_q.last)
	`HNR_ASSERT_IMPL(a_done_after_scan, state_q == S_TDONE, idx_q == LAST_SLOT)
	`HNR_ASSERT_NEXT(a_store_reports, state_q == S_STORE && out_free, rsp_valid_q && rsp_q.found && rsp_q.last && state_q == S_IDLE)
	`HNR_ASSERT_NEXT(a_active_grows, 1'b1, $countones(active_q) >= $past($countones(active_q)))

endmodule
